// ----- rtl/srs_pkg.sv -----
// ----------------------------------------------------------------------------
// srs_pkg
// Shared types and constants for the servo recipe sequencer: item kinds,
// recipe opcodes, result status codes, command characters and pulse widths.
// ----------------------------------------------------------------------------
package srs_pkg;

  // Field widths fixed by the item formats.
  localparam int MODE_W   = 2;
  localparam int CHAR_W   = 8;
  localparam int LIDX_W   = 7;
  localparam int WORD_W   = 8;
  localparam int OPC_W    = 3;
  localparam int ARG_W    = 5;
  localparam int POS_W    = 3;
  localparam int PULSE_W  = 15;
  localparam int STATUS_W = 3;
  localparam int PCOUT_W  = 8;
  localparam int CNT_W    = 5;
  localparam int NUM_POS  = 6;
  localparam int CIDX_W   = 3;

  // Stream widths: fields packed from bit 0, padded to whole bytes.
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;

  // Highest servo position.
  localparam logic [POS_W-1:0] POS_MAX = 3'd5;

  // Kind of an input item.
  typedef enum logic [MODE_W-1:0] {
    MODE_TICK = 2'd0,
    MODE_CMD  = 2'd1,
    MODE_LOAD = 2'd2
  } mode_t;

  // Recipe opcodes in the top three bits of a word.
  typedef enum logic [OPC_W-1:0] {
    OPC_END     = 3'd0,
    OPC_MOV     = 3'd1,
    OPC_WAIT    = 3'd2,
    OPC_LOOP    = 3'd4,
    OPC_ENDLOOP = 3'd5,
    OPC_RESET   = 3'd7
  } opc_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_IDLE    = 3'd0,
    ST_EXEC    = 3'd1,
    ST_WAIT    = 3'd2,
    ST_PAUSED  = 3'd3,
    ST_RANGE   = 3'd4,
    ST_EXTREME = 3'd5,
    ST_ENDED   = 3'd6,
    ST_UNKNOWN = 3'd7
  } status_t;

  // Console command characters, lower case.
  localparam logic [CHAR_W-1:0] CH_PAUSE    = 8'h70;  // p
  localparam logic [CHAR_W-1:0] CH_CONTINUE = 8'h63;  // c
  localparam logic [CHAR_W-1:0] CH_RIGHT    = 8'h72;  // r
  localparam logic [CHAR_W-1:0] CH_LEFT     = 8'h6C;  // l
  localparam logic [CHAR_W-1:0] CH_NOP      = 8'h6E;  // n
  localparam logic [CHAR_W-1:0] CH_RESTART  = 8'h62;  // b
  localparam logic [CHAR_W-1:0] CH_UPPER_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UPPER_Z  = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_CASE_OFS = 8'h20;

  // Pulse width registers after reset, in microseconds.
  localparam logic [PULSE_W-1:0] PULSE_RESET [NUM_POS] = '{
    15'd430, 15'd690, 15'd955, 15'd1220, 15'd1485, 15'd1750
  };

  // Channel state that does not depend on the store depth.
  typedef struct packed {
    logic             paused;
    logic [CNT_W-1:0] loop_cnt;
    logic [CNT_W-1:0] wait_cnt;
    logic [POS_W-1:0] pos;
  } srs_state_t;

endpackage

// ----- rtl/srs_ram.sv -----
// ----------------------------------------------------------------------------
// srs_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module srs_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 128,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/srs_store.sv -----
// ----------------------------------------------------------------------------
// srs_store
// Recipe word store: a RAM plus one valid bit per entry, so that an entry
// never loaded since reset reads as the zero (halt) word.
// ----------------------------------------------------------------------------
module srs_store #(
  parameter int DEPTH  = 128,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      wr_en,
  input  logic [ADDR_W-1:0]         wr_addr,
  input  logic [srs_pkg::WORD_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [ADDR_W-1:0]         rd_addr,
  output logic [srs_pkg::WORD_W-1:0] rd_data
);
  import srs_pkg::*;

  logic [DEPTH-1:0]  valid_r;
  logic              rd_valid_r;
  logic [WORD_W-1:0] ram_q;

  srs_ram #(
    .WIDTH  (WORD_W),
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  // Valid bits are set by loads and cleared only by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_r <= valid_r[rd_addr];
      end
    end
  end

  // An entry that was never loaded reads as zero.
  assign rd_data = rd_valid_r ? ram_q : '0;

endmodule

// ----- rtl/srs_exec.sv -----
// ----------------------------------------------------------------------------
// srs_exec
// Execute step: from the current channel state, the item kind, the command
// character and the recipe word at pc, forms the next state and the status.
// ----------------------------------------------------------------------------
module srs_exec #(
  parameter int RECIPE_DEPTH = 128,
  parameter int PC_W         = $clog2(RECIPE_DEPTH + 1)
) (
  input  srs_pkg::mode_t              mode,
  input  logic [srs_pkg::CHAR_W-1:0]  cmd_char,
  input  logic [srs_pkg::WORD_W-1:0]  word,
  input  srs_pkg::srs_state_t         st_in,
  input  logic [PC_W-1:0]             pc_in,
  input  logic [PC_W-1:0]             loop_start_in,
  output srs_pkg::srs_state_t         st_out,
  output logic [PC_W-1:0]             pc_out,
  output logic [PC_W-1:0]             loop_start_out,
  output srs_pkg::status_t            status
);
  import srs_pkg::*;

  opc_t             opc;
  logic [ARG_W-1:0] arg;
  logic [POS_W-1:0] arg_pos;
  logic [POS_W-1:0] travel;
  logic [CHAR_W-1:0] ch_low;
  logic [PC_W-1:0]  pc_inc;
  logic             pc_end;

  // Word decode, move distance and lower-cased command character.
  always_comb begin
    opc     = opc_t'(word[WORD_W-1 -: OPC_W]);
    arg     = word[ARG_W-1:0];
    arg_pos = arg[POS_W-1:0];
    travel  = (arg_pos > st_in.pos) ? (arg_pos - st_in.pos) : (st_in.pos - arg_pos);
    pc_inc  = pc_in + 1'b1;
    pc_end  = (pc_in >= PC_W'(RECIPE_DEPTH));
    if (cmd_char >= CH_UPPER_A && cmd_char <= CH_UPPER_Z) begin
      ch_low = cmd_char + CH_CASE_OFS;
    end else begin
      ch_low = cmd_char;
    end
  end

  // Next state and status.
  always_comb begin
    st_out         = st_in;
    pc_out         = pc_in;
    loop_start_out = loop_start_in;
    status         = ST_IDLE;
    case (mode)
      MODE_TICK: begin
        if (st_in.wait_cnt != '0) begin
          st_out.wait_cnt = st_in.wait_cnt - 1'b1;
          status          = ST_WAIT;
        end else if (st_in.paused) begin
          status = ST_PAUSED;
        end else if (pc_end || word == '0 || opc == OPC_END) begin
          status = ST_ENDED;
        end else begin
          case (opc)
            OPC_MOV: begin
              pc_out = pc_inc;
              if (arg > ARG_W'(POS_MAX)) begin
                status = ST_RANGE;
              end else begin
                st_out.wait_cnt = CNT_W'({travel, 1'b0});
                st_out.pos      = arg_pos;
                status          = ST_EXEC;
              end
            end
            OPC_WAIT: begin
              st_out.wait_cnt = arg;
              pc_out          = pc_inc;
              status          = ST_EXEC;
            end
            OPC_LOOP: begin
              st_out.loop_cnt = arg;
              loop_start_out  = pc_inc;
              pc_out          = pc_inc;
              status          = ST_EXEC;
            end
            OPC_ENDLOOP: begin
              if (st_in.loop_cnt != '0) begin
                pc_out          = loop_start_in;
                st_out.loop_cnt = st_in.loop_cnt - 1'b1;
              end else begin
                pc_out = pc_inc;
              end
              status = ST_EXEC;
            end
            OPC_RESET: begin
              pc_out = '0;
              status = ST_EXEC;
            end
            default: begin
              status = ST_UNKNOWN;
            end
          endcase
        end
      end
      MODE_CMD: begin
        case (ch_low)
          CH_PAUSE: begin
            st_out.paused = 1'b1;
            status        = ST_PAUSED;
          end
          CH_CONTINUE: begin
            st_out.paused = 1'b0;
          end
          CH_RIGHT: begin
            if (st_in.pos == '0) begin
              status = ST_EXTREME;
            end else begin
              st_out.pos      = st_in.pos - 1'b1;
              st_out.wait_cnt = CNT_W'(2);
              status          = ST_EXEC;
            end
          end
          CH_LEFT: begin
            if (st_in.pos >= POS_MAX) begin
              status = ST_EXTREME;
            end else begin
              st_out.pos      = st_in.pos + 1'b1;
              st_out.wait_cnt = CNT_W'(2);
              status          = ST_EXEC;
            end
          end
          CH_NOP: begin
            status = ST_IDLE;
          end
          CH_RESTART: begin
            pc_out        = '0;
            st_out.paused = 1'b0;
          end
          default: begin
            status = ST_UNKNOWN;
          end
        endcase
      end
      default: begin
        // Loads are handled by the store; the unused kind does nothing.
        status = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/servo_recipe_sequencer_top.sv -----
// ----------------------------------------------------------------------------
// servo_recipe_sequencer_top
// One servo channel stepping through a recipe held in a word store, driven
// by ticks and console command characters, one result per item.
// ----------------------------------------------------------------------------
// When an item is accepted the recipe store is read at the program counter;
// the word arrives in the next cycle from the synchronous memory, and the
// item executes once the output register can take its result, so the input
// stays closed until then. The result sits in an output register, and the
// next item is accepted while that result waits. Loaded words are written in
// the cycle the load is accepted. The store comes out of reset reading all
// zero at once, with no clearing pass. Pulse width registers may be written
// at any time the block is idle.
module servo_recipe_sequencer_top #(
  parameter int RECIPE_DEPTH = 128
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Input items.
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // in_tdata, from bit 0: cmd_char[7:0], load_index[14:8], load_word[22:15]
  input  logic [srs_pkg::IN_TDATA_W-1:0]     in_tdata,
  // in_tuser: mode[1:0]
  input  logic [srs_pkg::MODE_W-1:0]         in_tuser,
  // Results.
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // out_tdata, from bit 0: position[2:0], pulse_width[17:3], status[20:18],
  // program_counter[28:21]
  output logic [srs_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // Configuration writes.
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [srs_pkg::CIDX_W-1:0]         cfg_index,
  input  logic [srs_pkg::PULSE_W-1:0]        cfg_data
);
  import srs_pkg::*;

  localparam int ADDR_W = $clog2(RECIPE_DEPTH);
  localparam int PC_W   = $clog2(RECIPE_DEPTH + 1);

  // Input field unpacking.
  logic [CHAR_W-1:0] in_cmd_char;
  logic [LIDX_W-1:0] in_load_index;
  logic [WORD_W-1:0] in_load_word;
  mode_t             in_mode;
  logic              in_fire;
  logic              load_en;

  assign in_cmd_char   = in_tdata[CHAR_W-1:0];
  assign in_load_index = in_tdata[CHAR_W +: LIDX_W];
  assign in_load_word  = in_tdata[CHAR_W + LIDX_W +: WORD_W];
  assign in_mode       = mode_t'(in_tuser);
  assign in_fire       = in_tvalid && in_tready;
  assign load_en       = in_fire && (in_mode == MODE_LOAD)
                         && (32'(in_load_index) < RECIPE_DEPTH);

  // Channel state.
  srs_state_t        st_r;
  logic [PC_W-1:0]   pc_r;
  logic [PC_W-1:0]   loop_start_r;
  logic [PULSE_W-1:0] pulse_r [NUM_POS];

  // Execute stage holding the accepted item while its word is read.
  logic              s1_valid_r;
  mode_t             s1_mode_r;
  logic [CHAR_W-1:0] s1_cmd_r;
  logic              s1_fire;

  // Output register.
  logic               out_valid_r;
  logic [POS_W-1:0]   out_pos_r;
  logic [PULSE_W-1:0] out_pulse_r;
  status_t            out_status_r;
  logic [PCOUT_W-1:0] out_pc_r;

  // Execute results.
  logic [WORD_W-1:0]  rd_word;
  srs_state_t         st_nxt;
  logic [PC_W-1:0]    pc_nxt;
  logic [PC_W-1:0]    loop_start_nxt;
  status_t            status_nxt;
  logic [PULSE_W-1:0] pulse_nxt;

  assign in_tready = !s1_valid_r;
  assign s1_fire   = s1_valid_r && (!out_valid_r || out_tready);
  assign cfg_ready = 1'b1;

  srs_store #(
    .DEPTH  (RECIPE_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (load_en),
    .wr_addr (ADDR_W'(in_load_index)),
    .wr_data (in_load_word),
    .rd_en   (in_fire),
    .rd_addr (pc_r[ADDR_W-1:0]),
    .rd_data (rd_word)
  );

  srs_exec #(
    .RECIPE_DEPTH (RECIPE_DEPTH),
    .PC_W         (PC_W)
  ) u_exec (
    .mode           (s1_mode_r),
    .cmd_char       (s1_cmd_r),
    .word           (rd_word),
    .st_in          (st_r),
    .pc_in          (pc_r),
    .loop_start_in  (loop_start_r),
    .st_out         (st_nxt),
    .pc_out         (pc_nxt),
    .loop_start_out (loop_start_nxt),
    .status         (status_nxt)
  );

  // Pulse width of the position after this item.
  always_comb begin
    case (st_nxt.pos)
      3'd0:    pulse_nxt = pulse_r[0];
      3'd1:    pulse_nxt = pulse_r[1];
      3'd2:    pulse_nxt = pulse_r[2];
      3'd3:    pulse_nxt = pulse_r[3];
      3'd4:    pulse_nxt = pulse_r[4];
      default: pulse_nxt = pulse_r[5];
    endcase
  end

  // Pulse width registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_POS; i++) begin
        pulse_r[i] <= PULSE_RESET[i];
      end
    end else if (cfg_valid && cfg_ready && (cfg_index < CIDX_W'(NUM_POS))) begin
      pulse_r[cfg_index] <= cfg_data;
    end
  end

  // Execute stage control and channel state update.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      st_r         <= '0;
      pc_r         <= '0;
      loop_start_r <= '0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_fire) begin
        st_r         <= st_nxt;
        pc_r         <= pc_nxt;
        loop_start_r <= loop_start_nxt;
      end
    end
  end

  // Item payload captured at acceptance.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_mode_r <= in_mode;
      s1_cmd_r  <= in_cmd_char;
    end
  end

  // Output register: filled by the execute stage, emptied by the consumer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_pos_r    <= st_nxt.pos;
      out_pulse_r  <= pulse_nxt;
      out_status_r <= status_nxt;
      out_pc_r     <= PCOUT_W'(pc_nxt);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_pc_r, out_status_r, out_pulse_r, out_pos_r};

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking regression for servo_recipe_sequencer_top. A scoreboard
// class keeps its own copy of the servo channel and the pulse registers,
// works out the result of every accepted item and compares it, field by
// field, with what the block returns. Stimulus is a short directed run
// followed by random recipe programs, noise items and a full sweep of the
// recipe store, under three stall profiles and several pulse settings.
// ----------------------------------------------------------------------------
module testbench;
  import srs_pkg::*;

  localparam int RECIPE_DEPTH = 128;

  // Item kind that the block treats as a no-op.
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
  // Opcodes that the block does not support.
  localparam logic [OPC_W-1:0] OPC_SPARE_A = 3'd3;
  localparam logic [OPC_W-1:0] OPC_SPARE_B = 3'd6;
  // Configuration register indexes.
  localparam logic [CIDX_W-1:0] REG_PULSE_POS0 = 3'd0;
  localparam logic [CIDX_W-1:0] REG_SPARE_6    = 3'd6;
  localparam logic [CIDX_W-1:0] REG_SPARE_7    = 3'd7;
  localparam logic [PULSE_W-1:0] PULSE_MAX = 15'd20000;
  // Ticks of settling loaded by a single console step.
  localparam logic [CNT_W-1:0] STEP_SETTLE = 5'd2;

  typedef struct {
    logic [POS_W-1:0]   position;
    logic [PULSE_W-1:0] pulse_width;
    status_t            status;
    logic [PCOUT_W-1:0] pc;
  } servo_report_t;

  // Scoreboard: mirrors the servo channel and checks each result in order.
  class servo_scoreboard;
    logic [WORD_W-1:0]  recipe [RECIPE_DEPTH];
    logic [PULSE_W-1:0] pulse [NUM_POS];
    int                 pc;
    int                 loop_begin;
    logic [POS_W-1:0]   pos;
    logic [CNT_W-1:0]   wait_cnt;
    logic [CNT_W-1:0]   loop_cnt;
    bit                 paused;
    servo_report_t      awaited_reports [$];
    int                 errors;
    int                 checked;
    int                 deepest_pc;
    logic [7:0]         status_seen;

    function new();
      foreach (recipe[k]) recipe[k] = '0;
      foreach (pulse[k]) pulse[k] = PULSE_RESET[k];
      pc = 0;
      loop_begin = 0;
      pos = '0;
      wait_cnt = '0;
      loop_cnt = '0;
      paused = 1'b0;
      errors = 0;
      checked = 0;
      deepest_pc = 0;
      status_seen = '0;
    endfunction

    function void set_pulse(logic [CIDX_W-1:0] idx, logic [PULSE_W-1:0] val);
      if (idx < NUM_POS) pulse[idx] = val;
    endfunction

    function int pending();
      return awaited_reports.size();
    endfunction

    // Apply one accepted item to the mirrored state and queue its result.
    function void note_item(logic [MODE_W-1:0] mode, logic [CHAR_W-1:0] ch,
                            logic [LIDX_W-1:0] idx, logic [WORD_W-1:0] word);
      servo_report_t      rep;
      logic [WORD_W-1:0]  cur;
      logic [ARG_W-1:0]   arg;
      logic [CHAR_W-1:0]  lc;
      logic [POS_W-1:0]   travel;
      status_t            st;
      st = ST_IDLE;
      if (mode == MODE_TICK) begin
        // A pending wait always takes the tick, even while paused.
        if (wait_cnt != 0) begin
          wait_cnt--;
          st = ST_WAIT;
        end else if (paused) begin
          st = ST_PAUSED;
        end else if (pc >= RECIPE_DEPTH) begin
          st = ST_ENDED;
        end else begin
          cur = recipe[pc];
          arg = cur[ARG_W-1:0];
          if (cur[WORD_W-1:ARG_W] == OPC_END) begin
            st = ST_ENDED;
          end else begin
            st = ST_EXEC;
            case (cur[WORD_W-1:ARG_W])
              OPC_MOV: begin
                pc++;
                if (arg > POS_MAX) begin
                  st = ST_RANGE;
                end else begin
                  travel = (arg > pos) ? POS_W'(arg - pos) : POS_W'(pos - arg);
                  wait_cnt = CNT_W'(2 * travel);
                  pos = arg[POS_W-1:0];
                end
              end
              OPC_WAIT: begin
                wait_cnt = arg;
                pc++;
              end
              OPC_LOOP: begin
                loop_cnt = arg;
                loop_begin = pc + 1;
                pc++;
              end
              OPC_ENDLOOP: begin
                if (loop_cnt != 0) begin
                  pc = loop_begin;
                  loop_cnt--;
                end else begin
                  pc++;
                end
              end
              OPC_RESET: pc = 0;
              default: st = ST_UNKNOWN;
            endcase
          end
        end
      end else if (mode == MODE_CMD) begin
        // Commands are case-insensitive.
        lc = (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) ? ch + CH_CASE_OFS : ch;
        case (lc)
          CH_PAUSE: begin
            paused = 1'b1;
            st = ST_PAUSED;
          end
          CH_CONTINUE: paused = 1'b0;
          CH_RIGHT: begin
            if (pos == 0) begin
              st = ST_EXTREME;
            end else begin
              pos--;
              wait_cnt = STEP_SETTLE;
              st = ST_EXEC;
            end
          end
          CH_LEFT: begin
            if (pos >= POS_MAX) begin
              st = ST_EXTREME;
            end else begin
              pos++;
              wait_cnt = STEP_SETTLE;
              st = ST_EXEC;
            end
          end
          CH_NOP: ;
          CH_RESTART: begin
            pc = 0;
            paused = 1'b0;
          end
          default: st = ST_UNKNOWN;
        endcase
      end else if (mode == MODE_LOAD) begin
        if (idx < RECIPE_DEPTH) recipe[idx] = word;
      end
      rep.position = pos;
      rep.pulse_width = pulse[pos];
      rep.status = st;
      rep.pc = PCOUT_W'(pc);
      awaited_reports.push_back(rep);
      status_seen[st] = 1'b1;
      if (pc > deepest_pc) deepest_pc = pc;
    endfunction

    // Compare one result with the oldest queued expectation.
    function void check_report(logic [OUT_TDATA_W-1:0] d);
      servo_report_t      exp_rep;
      logic [POS_W-1:0]   got_pos;
      logic [PULSE_W-1:0] got_pulse;
      logic [STATUS_W-1:0] got_status;
      logic [PCOUT_W-1:0] got_pc;
      got_pos = d[2:0];
      got_pulse = d[17:3];
      got_status = d[20:18];
      got_pc = d[28:21];
      if (awaited_reports.size() == 0) begin
        $error("result %h arrived with no expectation waiting", d);
        errors++;
        return;
      end
      exp_rep = awaited_reports.pop_front();
      checked++;
      if (got_pos !== exp_rep.position) begin
        $error("position: expected %0d, actual %0d", exp_rep.position, got_pos);
        errors++;
      end
      if (got_pulse !== exp_rep.pulse_width) begin
        $error("pulse_width: expected %0d, actual %0d", exp_rep.pulse_width, got_pulse);
        errors++;
      end
      if (got_status !== exp_rep.status) begin
        $error("status: expected %0d, actual %0d", exp_rep.status, got_status);
        errors++;
      end
      if (got_pc !== exp_rep.pc) begin
        $error("program_counter: expected %0d, actual %0d", exp_rep.pc, got_pc);
        errors++;
      end
    endfunction
  endclass

  logic                     clk;
  logic                     rst_n = 1'b0;
  logic                     in_tvalid = 1'b0;
  logic                     in_tready;
  logic [IN_TDATA_W-1:0]    in_tdata = '0;
  logic [MODE_W-1:0]        in_tuser = '0;
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]   out_tdata;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CIDX_W-1:0]        cfg_index = '0;
  logic [PULSE_W-1:0]       cfg_data = '0;

  servo_scoreboard sb;
  int send_idle_pct = 8;
  int recv_idle_pct = 79;
  int items_sent = 0;
  int pulse_settings = 1;

  servo_recipe_sequencer_top #(
    .RECIPE_DEPTH(RECIPE_DEPTH)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver stalls at the rate of the current profile.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Every result transaction is checked against the scoreboard.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_report(out_tdata);
  end

  // Offer one item and wait for its transaction. The valid stays high
  // afterwards so that back-to-back items need no extra edge.
  task automatic send_item(input logic [MODE_W-1:0] mode, input logic [CHAR_W-1:0] ch,
                           input logic [LIDX_W-1:0] idx, input logic [WORD_W-1:0] word);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= mode;
    in_tdata <= {1'b0, word, idx, ch};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_item(mode, ch, idx, word);
    items_sent++;
  endtask

  task automatic tick();
    send_item(MODE_TICK, CHAR_W'($urandom), LIDX_W'($urandom), WORD_W'($urandom));
  endtask

  task automatic command(input logic [CHAR_W-1:0] ch);
    send_item(MODE_CMD, ch, LIDX_W'($urandom), WORD_W'($urandom));
  endtask

  task automatic load(input logic [LIDX_W-1:0] idx, input logic [WORD_W-1:0] word);
    send_item(MODE_LOAD, CHAR_W'($urandom), idx, word);
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [PULSE_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_pulse(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Close the input and wait until every expected result has come back.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Load all six pulse registers in one of three styles.
  task automatic program_pulses(input int style);
    for (int i = 0; i < NUM_POS; i++) begin
      case (style)
        0: write_reg(REG_PULSE_POS0 + CIDX_W'(i), (i % 2 == 0) ? '0 : PULSE_MAX);
        1: write_reg(REG_PULSE_POS0 + CIDX_W'(i), (i % 2 == 0) ? PULSE_MAX : '0);
        default: write_reg(REG_PULSE_POS0 + CIDX_W'(i), PULSE_W'($urandom_range(20000)));
      endcase
    end
    // Indexes past the last position must leave everything alone.
    if (style == 1) begin
      write_reg(REG_SPARE_6, PULSE_W'($urandom_range(20000)));
      write_reg(REG_SPARE_7, PULSE_W'($urandom_range(20000)));
    end
    pulse_settings++;
  endtask

  function automatic logic [CHAR_W-1:0] pick_command();
    logic [CHAR_W-1:0] c;
    case ($urandom_range(7))
      0: c = CH_PAUSE;
      1: c = CH_CONTINUE;
      2: c = CH_RIGHT;
      3: c = CH_LEFT;
      4: c = CH_NOP;
      5: c = CH_RESTART;
      default: return CHAR_W'($urandom_range(255));
    endcase
    if ($urandom_range(1) == 1) c = c - CH_CASE_OFS;
    return c;
  endfunction

  function automatic logic [WORD_W-1:0] body_word();
    logic [ARG_W-1:0] arg;
    case ($urandom_range(9))
      0, 1, 2, 3: begin
        arg = ($urandom_range(7) == 0) ? ARG_W'($urandom_range(6, 31))
                                       : ARG_W'($urandom_range(5));
        return {OPC_MOV, arg};
      end
      4, 5: begin
        arg = ($urandom_range(9) == 0) ? ARG_W'($urandom_range(31))
                                       : ARG_W'($urandom_range(3));
        return {OPC_WAIT, arg};
      end
      6, 7: return {OPC_LOOP, ARG_W'($urandom_range(3))};
      default: return {OPC_ENDLOOP, ARG_W'($urandom_range(31))};
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] closing_word();
    case ($urandom_range(4))
      0: return '0;
      1: return {OPC_END, ARG_W'($urandom_range(1, 31))};
      2: return {OPC_RESET, ARG_W'($urandom_range(31))};
      3: return {OPC_SPARE_A, ARG_W'($urandom_range(31))};
      default: return {OPC_SPARE_B, ARG_W'($urandom_range(31))};
    endcase
  endfunction

  // Mostly whole recipe programs run from word 0, with noise mixed in.
  task automatic run_random(input int quota);
    int start_count;
    int len;
    int ticks;
    start_count = items_sent;
    while (items_sent - start_count < quota) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5, 6: begin
          len = $urandom_range(2, 10);
          for (int k = 0; k < len; k++) load(LIDX_W'(k), body_word());
          load(LIDX_W'(len), closing_word());
          command(($urandom_range(1) == 1) ? CH_RESTART : CH_RESTART - CH_CASE_OFS);
          ticks = $urandom_range(6, 30);
          for (int k = 0; k < ticks; k++) begin
            if ($urandom_range(9) == 0) command(pick_command());
            else tick();
          end
        end
        7: load(LIDX_W'($urandom_range(127)), WORD_W'($urandom_range(255)));
        8: command(pick_command());
        default: begin
          if ($urandom_range(1) == 1) tick();
          else send_item(MODE_SPARE, CHAR_W'($urandom), LIDX_W'($urandom),
                         WORD_W'($urandom));
        end
      endcase
    end
  endtask

  initial begin
    int guard;
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed run at the reset pulse widths.
    tick();                                   // empty store halts
    command(CH_RIGHT);                        // right step at position 0
    load(7'd0, {OPC_MOV, 5'd1});
    load(7'd1, {OPC_MOV, 5'd7});              // move out of range
    load(7'd2, {OPC_WAIT, 5'd0});
    load(7'd3, {OPC_LOOP, 5'd1});
    load(7'd4, {OPC_ENDLOOP, 5'd0});
    load(7'd5, {OPC_SPARE_A, 5'd0});          // unsupported opcode
    load(7'd127, 8'hFF);
    tick();                                   // move to 1
    command(CH_LEFT - CH_CASE_OFS);
    command(CH_LEFT);
    command(CH_LEFT);
    command(CH_LEFT);                         // now at position 5
    command(CH_LEFT);                         // left step at the extreme
    command(CH_PAUSE);
    tick();
    tick();                                   // waits still count down
    tick();                                   // paused
    command(CH_CONTINUE - CH_CASE_OFS);
    tick();                                   // move out of range
    tick();                                   // wait 0
    tick();                                   // loop once
    tick();                                   // end of loop jumps back
    tick();                                   // end of loop falls through
    tick();                                   // unsupported opcode
    command(8'hFF);                           // unknown character
    send_item(MODE_SPARE, 8'hFF, 7'h7F, 8'hFF);
    command(CH_RESTART - CH_CASE_OFS);

    // First profile: sender rarely idle, receiver mostly stalled.
    drain();
    program_pulses(0);
    run_random(30);

    // Second profile: the other way round.
    drain();
    send_idle_pct = 79;
    recv_idle_pct = 8;
    program_pulses(1);
    run_random(30);

    // Third profile: no idling on either side.
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    program_pulses(2);
    run_random(20);

    // Sweep the whole store so that the counter runs off its end.
    for (int k = 0; k < RECIPE_DEPTH; k++) begin
      load(LIDX_W'(k), ($urandom_range(9) < 9) ? {OPC_WAIT, 5'd0}
                                                : {OPC_MOV, ARG_W'($urandom_range(5))});
    end
    command(CH_RESTART);
    guard = 0;
    while (sb.pc < RECIPE_DEPTH && guard < 2000) begin
      tick();
      guard++;
    end
    tick();
    tick();

    drain();
    repeat (8) @(posedge clk);
    $display("Ran %0d items with %0d results checked under three stall profiles",
             items_sent, sb.checked);
    $display("and %0d pulse settings; program counter reached %0d, statuses seen %b.",
             pulse_settings, sb.deepest_pc, sb.status_seen);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("servo_recipe_sequencer_top regression: pass");
    end else begin
      $display("servo_recipe_sequencer_top regression: fail");
    end
    $finish;
  end

  // Hard stop if a handshake never completes.
  initial begin
    #5_000_000;
    $display("servo_recipe_sequencer_top regression: fail");
    $finish;
  end

endmodule
